// File: rtl/fcp_pkg.sv
// ----------------------------------------------------------------------------
// Form credentials parser package
// Shared item types, codes and character constants for the parser block.
// ----------------------------------------------------------------------------
package fcp_pkg;

  // Input item: one raw byte of the form body.
  typedef struct packed {
    logic [7:0] body_byte;
    logic       last_byte;
  } in_item_t;

  // Result item: a decoded value byte or the closing verdict.
  typedef struct packed {
    logic [1:0] item_kind;
    logic [7:0] data_byte;
    logic [2:0] status_code;
    logic       end_of_body;
  } out_item_t;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_NAME     = 2'd0,
    KIND_PASSWORD = 2'd1,
    KIND_VERDICT  = 2'd2
  } kind_e;

  // Verdict status codes.
  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_MALFORMED   = 3'd1,
    ST_BAD_ESCAPE  = 3'd2,
    ST_BAD_KEY     = 3'd3,
    ST_MISSING_KEY = 3'd4,
    ST_BAD_LENGTH  = 3'd5
  } status_e;

  // Parser phases.
  typedef enum logic [1:0] {
    PH_KEY = 2'd0,
    PH_VAL = 2'd1,
    PH_HI  = 2'd2,
    PH_LO  = 2'd3
  } phase_e;

  // Configuration register indexes.
  localparam logic REG_SSID_MAX = 1'b0;
  localparam logic REG_PASS_MAX = 1'b1;

  // Length limits and caps.
  localparam logic [5:0] NAME_CAP = 6'd32;
  localparam logic [6:0] PASS_CAP = 7'd64;
  localparam logic [5:0] NAME_SAT = 6'd63;
  localparam logic [6:0] PASS_SAT = 7'd127;
  localparam logic [3:0] KEY_POS_SAT = 4'd15;
  localparam logic [3:0] NAME_KEY_LEN = 4'd4;
  localparam logic [3:0] PASS_KEY_LEN = 4'd8;

  // Delimiters.
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SPACE = 8'h20;

  // Work item handed from the front part to the back part.
  typedef struct packed {
    logic       value_vld;
    logic       field;
    logic [7:0] data;
    logic       has_verdict;
    logic [2:0] status;
  } op_t;

  // Characters of the "ssid" key.
  function automatic logic [7:0] name_key_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = 8'h73;
      2'd1:    c = 8'h73;
      2'd2:    c = 8'h69;
      2'd3:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Characters of the "password" key.
  function automatic logic [7:0] pass_key_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = 8'h70;
      3'd1:    c = 8'h61;
      3'd2:    c = 8'h73;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h77;
      3'd5:    c = 8'h6f;
      3'd6:    c = 8'h72;
      3'd7:    c = 8'h64;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Hex digit decode: bit 4 flags a valid digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

// File: rtl/form_credentials_parser_top.sv
// ----------------------------------------------------------------------------
// Form credentials parser
// Checks a URL-encoded ssid/password form body and emits the decoded values.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_item_i) takes one raw body byte
//   per item; last_byte marks the end of the body. Output channel
//   (out_valid_o/out_ready_i/out_item_o) gives decoded value bytes tagged
//   with their field, and one verdict item with end_of_body set per body.
//   The configuration port writes the two maximum lengths; write it only
//   while the block is idle.
//   Each result is held in the work queue before it appears at the output.
//   Throughput: one byte per cycle while the work queue is not full. A last
//   byte that also yields a value byte produces two results, value first.
//   The parser front end and the output back end are joined by a work queue
//   of QUEUE_DEPTH entries; when the receiver stalls, the queue fills and
//   in_ready_o drops only once it is full.
//   Reset clears the parser state and the queue, and sets the maxima to
//   32 and 64.
// ----------------------------------------------------------------------------
module form_credentials_parser_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [6:0]         cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  fcp_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output fcp_pkg::out_item_t out_item_o
);
  import fcp_pkg::*;

  logic q_full, q_empty, push, pop;
  op_t  push_op, head_op;

  // Front end: parsing and classification.
  fcp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_op_o   (push_op)
  );

  // Work queue between the two parts.
  fcp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .full_o    (q_full),
    .pop_i     (pop),
    .empty_o   (q_empty),
    .head_o    (head_op)
  );

  // Back end: result delivery.
  fcp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .head_i      (head_op),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

  // A verdict always closes the body, and only a verdict does.
  a_eob_is_verdict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.end_of_body == (out_item_o.item_kind == KIND_VERDICT)))
    else $error("end_of_body does not match the verdict kind");

  // Value items carry no status.
  a_value_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_item_o.item_kind != KIND_VERDICT) |->
      (out_item_o.status_code == ST_OK))
    else $error("value item with nonzero status");

  // A value byte taken with its verdict pending is followed by that verdict.
  a_verdict_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && out_item_o.item_kind != KIND_VERDICT &&
     head_op.has_verdict) |=>
      (out_valid_o && out_item_o.item_kind == KIND_VERDICT))
    else $error("pending verdict lost after value byte");

  // Nothing is pushed into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("push into full work queue");

endmodule

// File: rtl/fcp_front.sv
// ----------------------------------------------------------------------------
// Form credentials parser front end
// Accepts body bytes, runs the key/value parser and posts work items.
// ----------------------------------------------------------------------------
module fcp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_index_i,
  input  logic [6:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  fcp_pkg::in_item_t in_item_i,
  input  logic             q_full_i,
  output logic             push_o,
  output fcp_pkg::op_t     push_op_o
);
  import fcp_pkg::*;

  logic [5:0] ssid_max_q;
  logic [6:0] pass_max_q;

  phase_e     phase_q, phase_d;
  logic [3:0] pos_q, pos_d;
  logic [1:0] flags_q, flags_d;
  logic       field_q, field_d;
  logic       seen_name_q, seen_name_d;
  logic       seen_pass_q, seen_pass_d;
  logic [5:0] name_len_q, name_len_d;
  logic [6:0] pass_len_q, pass_len_d;
  logic [3:0] hi_q, hi_d;
  status_e    err_q, err_d;

  logic       emit_val;
  logic [7:0] val_data;
  logic [7:0] b;
  logic [4:0] hex;
  logic       is_name, is_pass;
  logic [5:0] nmax;
  logic [6:0] pmax;
  logic       fire;

  assign b          = in_item_i.body_byte;
  assign hex        = hex_nibble(b);
  assign in_ready_o = !q_full_i;
  assign fire       = in_valid_i && in_ready_o;
  assign is_name    = flags_q[0] && (pos_q == NAME_KEY_LEN);
  assign is_pass    = flags_q[1] && (pos_q == PASS_KEY_LEN);
  assign nmax       = (ssid_max_q > NAME_CAP) ? NAME_CAP : ssid_max_q;
  assign pmax       = (pass_max_q > PASS_CAP) ? PASS_CAP : pass_max_q;

  // Parser next state for the byte at the input.
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    flags_d     = flags_q;
    field_d     = field_q;
    seen_name_d = seen_name_q;
    seen_pass_d = seen_pass_q;
    hi_d        = hi_q;
    err_d       = err_q;
    emit_val    = 1'b0;
    val_data    = 8'h00;
    if (err_q == ST_OK) begin
      case (phase_q)
        PH_KEY: begin
          if (b == CH_AMP) begin
            err_d = ST_MALFORMED;
          end else if (b == CH_EQ) begin
            if (is_name && !seen_name_q) begin
              seen_name_d = 1'b1;
              field_d     = 1'b0;
              phase_d     = PH_VAL;
            end else if (is_pass && !seen_pass_q) begin
              seen_pass_d = 1'b1;
              field_d     = 1'b1;
              phase_d     = PH_VAL;
            end else begin
              err_d = ST_BAD_KEY;
            end
          end else begin
            if (pos_q >= NAME_KEY_LEN || name_key_char(pos_q[1:0]) != b) begin
              flags_d[0] = 1'b0;
            end
            if (pos_q >= PASS_KEY_LEN || pass_key_char(pos_q[2:0]) != b) begin
              flags_d[1] = 1'b0;
            end
            if (pos_q != KEY_POS_SAT) begin
              pos_d = pos_q + 4'd1;
            end
          end
        end
        PH_VAL: begin
          if (b == CH_AMP) begin
            phase_d = PH_KEY;
            pos_d   = 4'd0;
            flags_d = 2'b11;
          end else if (b == CH_PLUS) begin
            emit_val = 1'b1;
            val_data = CH_SPACE;
          end else if (b == CH_PCT) begin
            phase_d = PH_HI;
          end else begin
            emit_val = 1'b1;
            val_data = b;
          end
        end
        PH_HI: begin
          if (!hex[4]) begin
            err_d = ST_BAD_ESCAPE;
          end else begin
            hi_d    = hex[3:0];
            phase_d = PH_LO;
          end
        end
        default: begin
          if (!hex[4]) begin
            err_d = ST_BAD_ESCAPE;
          end else begin
            emit_val = 1'b1;
            val_data = {hi_q, hex[3:0]};
            phase_d  = PH_VAL;
          end
        end
      endcase
    end

    // Saturating length counters.
    name_len_d = name_len_q;
    pass_len_d = pass_len_q;
    if (emit_val) begin
      if (!field_q) begin
        if (name_len_q != NAME_SAT) name_len_d = name_len_q + 6'd1;
      end else begin
        if (pass_len_q != PASS_SAT) pass_len_d = pass_len_q + 7'd1;
      end
    end

    // End-of-body checks, in priority order.
    if (in_item_i.last_byte && err_d == ST_OK) begin
      if (phase_d == PH_KEY) begin
        err_d = ST_MALFORMED;
      end else if (phase_d != PH_VAL) begin
        err_d = ST_BAD_ESCAPE;
      end else if (!seen_name_d || !seen_pass_d) begin
        err_d = ST_MISSING_KEY;
      end else if (name_len_d == 6'd0 || name_len_d > nmax ||
                   pass_len_d == 7'd0 || pass_len_d > pmax) begin
        err_d = ST_BAD_LENGTH;
      end
    end
  end

  // Work item for the back end.
  always_comb begin
    push_op_o.value_vld   = emit_val;
    push_op_o.field       = field_q;
    push_op_o.data        = val_data;
    push_op_o.has_verdict = in_item_i.last_byte;
    push_op_o.status      = err_d;
  end
  assign push_o = fire && (emit_val || in_item_i.last_byte);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ssid_max_q <= NAME_CAP;
      pass_max_q <= PASS_CAP;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_SSID_MAX: ssid_max_q <= cfg_data_i[5:0];
        REG_PASS_MAX: pass_max_q <= cfg_data_i;
        default:      ;
      endcase
    end
  end

  // Parser state; a last byte clears the per-body state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_KEY;
      pos_q       <= 4'd0;
      flags_q     <= 2'b11;
      field_q     <= 1'b0;
      seen_name_q <= 1'b0;
      seen_pass_q <= 1'b0;
      name_len_q  <= 6'd0;
      pass_len_q  <= 7'd0;
      hi_q        <= 4'd0;
      err_q       <= ST_OK;
    end else if (fire) begin
      if (in_item_i.last_byte) begin
        phase_q     <= PH_KEY;
        pos_q       <= 4'd0;
        flags_q     <= 2'b11;
        field_q     <= 1'b0;
        seen_name_q <= 1'b0;
        seen_pass_q <= 1'b0;
        name_len_q  <= 6'd0;
        pass_len_q  <= 7'd0;
        hi_q        <= 4'd0;
        err_q       <= ST_OK;
      end else begin
        phase_q     <= phase_d;
        pos_q       <= pos_d;
        flags_q     <= flags_d;
        field_q     <= field_d;
        seen_name_q <= seen_name_d;
        seen_pass_q <= seen_pass_d;
        name_len_q  <= name_len_d;
        pass_len_q  <= pass_len_d;
        hi_q        <= hi_d;
        err_q       <= err_d;
      end
    end
  end

endmodule

// File: rtl/fcp_queue.sv
// ----------------------------------------------------------------------------
// Form credentials parser work queue
// Small FIFO of work items between the front end and the back end.
// ----------------------------------------------------------------------------
module fcp_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  fcp_pkg::op_t push_op_i,
  output logic         full_o,
  input  logic         pop_i,
  output logic         empty_o,
  output fcp_pkg::op_t head_o
);
  import fcp_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

  op_t           mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

// File: rtl/fcp_back.sv
// ----------------------------------------------------------------------------
// Form credentials parser back end
// Turns each work item into one or two result items on the output channel.
// ----------------------------------------------------------------------------
module fcp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              empty_i,
  input  fcp_pkg::op_t      head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output fcp_pkg::out_item_t out_item_o
);
  import fcp_pkg::*;

  logic value_done_q, value_done_d;
  logic send_value;
  logic fire;

  assign send_value  = head_i.value_vld && !value_done_q;
  assign out_valid_o = !empty_i;
  assign fire        = out_valid_o && out_ready_i;

  // The value byte goes first, the verdict after it.
  always_comb begin
    if (send_value) begin
      out_item_o.item_kind   = head_i.field ? KIND_PASSWORD : KIND_NAME;
      out_item_o.data_byte   = head_i.data;
      out_item_o.status_code = ST_OK;
      out_item_o.end_of_body = 1'b0;
    end else begin
      out_item_o.item_kind   = KIND_VERDICT;
      out_item_o.data_byte   = 8'h00;
      out_item_o.status_code = head_i.status;
      out_item_o.end_of_body = 1'b1;
    end
  end

  // Retire the work item once its last result is taken.
  always_comb begin
    pop_o        = fire && !(send_value && head_i.has_verdict);
    value_done_d = value_done_q;
    if (pop_o) begin
      value_done_d = 1'b0;
    end else if (fire && send_value) begin
      value_done_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_done_q <= 1'b0;
    end else begin
      value_done_q <= value_done_d;
    end
  end

endmodule
